FILE: hw/rtl/dlr_pkg.sv
// Shared types and constants of the delimited line receiver.
// No dependencies; every other file of the block imports this package.
package dlr_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 32;
  localparam int unsigned CMD_DEPTH        = 2;

  // receive_mode codes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_CHAR = 2'd1;
  localparam logic [1:0] MODE_TERM = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_RECEIVE_MODE = 2'd0;
  localparam logic [1:0] REG_TERM_LENGTH  = 2'd1;
  localparam logic [1:0] REG_TERM_LOW     = 2'd2;
  localparam logic [1:0] REG_TERM_HIGH    = 2'd3;

  localparam logic [63:0] TERM_LOW_RST  = 64'h0000_0000_0000_0A0D;
  localparam logic [3:0]  TERM_LEN_RST  = 4'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_complete;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_in_frame;
    logic [5:0] frame_length;
    logic       truncated;
  } result_t;

  typedef enum logic {
    CMD_CHAR,
    CMD_FRAME
  } cmd_kind_e;

  // Request from the front to the back: a single byte, or a finished frame in the store.
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data_byte;
    logic [7:0] count;
    logic       truncated;
  } cmd_t;

endpackage

FILE: hw/rtl/dlr_cmd_fifo.sv
// Short request queue between the front and the back of the line receiver.
// Depends on dlr_pkg for the request type and depth.
module dlr_cmd_fifo
  import dlr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int unsigned PtrW = $clog2(CMD_DEPTH);
  localparam int unsigned CntW = $clog2(CMD_DEPTH + 1);

  cmd_t            entry_q [CMD_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/dlr_front.sv
// Front of the line receiver: configuration registers, byte classification,
// terminator matching and frame store writes. Depends on dlr_pkg.
module dlr_front
  import dlr_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  input  in_item_t                        in_item_i,
  output logic                            full,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [63:0]                     cfg_wdata_i,
  output logic                            store_we_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0] store_addr_o,
  output logic [7:0]                      store_data_o,
  output logic                            cmd_push_o,
  output cmd_t                            cmd_o,
  input  logic                            cmd_full_i,
  input  logic                            frame_done_i
);

  localparam int unsigned AddrW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CntW  = $clog2(BUFFER_DEPTH + 1);

  logic [1:0]      mode_q;
  logic [3:0]      term_len_q;
  logic [63:0]     term_low_q;
  logic [55:0]     term_high_q;
  logic [CntW-1:0] stored_q, stored_d;
  logic [7:0]      total_q, total_d;
  logic [3:0]      pos_q, pos_d;
  logic            busy_q, busy_d;

  logic            accept;
  logic [3:0]      len;
  logic [3:0]      pos_eff;
  logic [3:0]      pos_next;
  logic [127:0]    term_vec;
  logic [7:0]      term_byte;
  logic [CntW-1:0] stored_new;
  logic [7:0]      payload;
  logic [7:0]      count;
  logic            trunc;

  assign full   = cmd_full_i || busy_q;
  assign accept = push && !full;

  assign len       = (term_len_q == '0) ? 4'd1 : term_len_q;
  assign pos_eff   = (pos_q >= len) ? '0 : pos_q;
  assign pos_next  = pos_eff + 4'd1;
  assign term_vec  = {8'h00, term_high_q, term_low_q};
  assign term_byte = term_vec[{pos_eff, 3'b000} +: 8];

  assign store_addr_o = stored_q[AddrW-1:0];
  assign store_data_o = in_item_i.rx_byte;

  always_comb begin
    stored_d   = stored_q;
    total_d    = total_q;
    pos_d      = pos_q;
    busy_d     = busy_q;
    store_we_o = 1'b0;
    cmd_push_o = 1'b0;
    stored_new = (stored_q < CntW'(BUFFER_DEPTH)) ? stored_q + 1'b1 : stored_q;
    payload    = ((total_q == 8'hFF) ? total_q : total_q + 8'd1);
    payload    = (payload >= {4'b0, len}) ? payload - {4'b0, len} : 8'd0;
    trunc      = (payload > 8'(BUFFER_DEPTH));
    count      = trunc ? 8'(BUFFER_DEPTH) : payload;
    if (count > 8'(stored_new)) begin
      count = 8'(stored_new);
    end
    cmd_o.kind      = CMD_FRAME;
    cmd_o.data_byte = in_item_i.rx_byte;
    cmd_o.count     = count;
    cmd_o.truncated = trunc;

    if (frame_done_i) begin
      busy_d = 1'b0;
    end

    if (accept && in_item_i.rx_complete) begin
      if (mode_q == MODE_CHAR) begin
        cmd_o.kind = CMD_CHAR;
        cmd_push_o = 1'b1;
      end else if (mode_q == MODE_TERM) begin
        store_we_o = (stored_q < CntW'(BUFFER_DEPTH));
        stored_d   = stored_new;
        total_d    = (total_q == 8'hFF) ? total_q : total_q + 8'd1;
        if (in_item_i.rx_byte != term_byte) begin
          pos_d = '0;
        end else if (pos_next != len) begin
          pos_d = pos_next;
        end else begin
          // terminator complete: hand the frame to the back and start over
          cmd_push_o = 1'b1;
          busy_d     = 1'b1;
          stored_d   = '0;
          total_d    = '0;
          pos_d      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_TERM;
      term_len_q  <= TERM_LEN_RST;
      term_low_q  <= TERM_LOW_RST;
      term_high_q <= '0;
      stored_q    <= '0;
      total_q     <= '0;
      pos_q       <= '0;
      busy_q      <= 1'b0;
    end else begin
      stored_q <= stored_d;
      total_q  <= total_d;
      pos_q    <= pos_d;
      busy_q   <= busy_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RECEIVE_MODE: mode_q      <= cfg_wdata_i[1:0];
          REG_TERM_LENGTH:  term_len_q  <= cfg_wdata_i[3:0];
          REG_TERM_LOW:     term_low_q  <= cfg_wdata_i;
          REG_TERM_HIGH:    term_high_q <= cfg_wdata_i[55:0];
          default:          ;
        endcase
      end
    end
  end

endmodule

FILE: hw/rtl/dlr_back.sv
// Back of the line receiver: frame store memory, byte emitter and result register.
// Depends on dlr_pkg for the request and result types.
module dlr_back
  import dlr_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            store_we_i,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] store_addr_i,
  input  logic [7:0]                      store_data_i,
  input  logic                            cmd_empty_i,
  input  cmd_t                            cmd_i,
  output logic                            cmd_pop_o,
  output logic                            frame_done_o,
  output logic                            empty,
  input  logic                            pop,
  output result_t                         result_o
);

  localparam int unsigned AddrW = $clog2(BUFFER_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [7:0]       mem_q [BUFFER_DEPTH];
  logic [7:0]       rd_data_q;
  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [7:0]       cnt_q, cnt_d;
  logic             trunc_q, trunc_d;
  logic             char_q, char_d;
  logic [7:0]       byte_q, byte_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, out_d;
  result_t          res;
  logic             last;
  logic             slot_free;

  assign empty     = !out_valid_q;
  assign result_o  = out_q;
  assign slot_free = !out_valid_q || pop;
  assign last      = (8'(idx_q) + 8'd1 == cnt_q);

  always_comb begin
    if (char_q) begin
      res = '{data_byte: byte_q, byte_valid: 1'b1, last_in_frame: 1'b1,
              frame_length: 6'd1, truncated: 1'b0};
    end else if (cnt_q == '0) begin
      res = '{data_byte: 8'h00, byte_valid: 1'b0, last_in_frame: 1'b1,
              frame_length: 6'd0, truncated: trunc_q};
    end else begin
      res = '{data_byte: rd_data_q, byte_valid: 1'b1, last_in_frame: last,
              frame_length: cnt_q[5:0], truncated: trunc_q};
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    trunc_d      = trunc_q;
    char_d       = char_q;
    byte_d       = byte_q;
    out_valid_d  = out_valid_q && !pop;
    out_d        = out_q;
    cmd_pop_o    = 1'b0;
    frame_done_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          char_d    = (cmd_i.kind == CMD_CHAR);
          byte_d    = cmd_i.data_byte;
          cnt_d     = cmd_i.count;
          trunc_d   = cmd_i.truncated;
          idx_d     = '0;
          state_d   = (cmd_i.kind == CMD_FRAME && cmd_i.count != '0) ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: begin
        // wait for the registered memory read
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = res;
          if (!char_q && cnt_q != '0 && !last) begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_READ;
          end else begin
            frame_done_o = !char_q;
            state_d      = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    trunc_q <= trunc_d;
    char_q  <= char_d;
    byte_q  <= byte_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (store_we_i) begin
      mem_q[store_addr_i] <= store_data_i;
    end
    rd_data_q <= mem_q[idx_q];
  end

endmodule

FILE: hw/rtl/delimited_line_receiver_unit.sv
// Top level of the delimited line receiver; instantiates dlr_front, dlr_cmd_fifo and
// dlr_back and depends on dlr_pkg.
//
// Receives UART bytes and frames them: mode 0 drops bytes, mode 1 passes each byte as a
// one-byte frame, mode 2 collects bytes in a BUFFER_DEPTH-byte store until the
// programmed terminator (CR LF after reset) is seen, then delivers the payload one byte
// per result, without the terminator, with truncated set when it did not fit. A byte is
// taken while no frame is being delivered and the request queue has room; a single-byte
// result passes the request queue and the back's emit state into the result register,
// and the back takes the next such byte only after it has placed the last one there. When
// a terminator completes, input stays full until the frame has been read out of the store:
// each payload byte goes through a registered memory read and then the result register,
// and a stalling consumer holds the readout. There is no clearing pass after reset.
module delimited_line_receiver_unit
  import dlr_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output result_t     result_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(BUFFER_DEPTH);

  logic             store_we;
  logic [AddrW-1:0] store_addr;
  logic [7:0]       store_data;
  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t             cmd_in, cmd_out;
  logic             frame_done;

  dlr_front #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .push,
    .in_item_i,
    .full,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .store_we_o   (store_we),
    .store_addr_o (store_addr),
    .store_data_o (store_data),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in),
    .cmd_full_i   (cmd_full),
    .frame_done_i (frame_done)
  );

  dlr_cmd_fifo u_cmd_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  dlr_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .store_we_i   (store_we),
    .store_addr_i (store_addr),
    .store_data_i (store_data),
    .cmd_empty_i  (cmd_empty),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (cmd_pop),
    .frame_done_o (frame_done),
    .empty,
    .pop,
    .result_o
  );

endmodule

FILE: hw/rtl/dlr_checker.sv
// Port-level checks of the delimited line receiver, bound to the top level.
// Depends on dlr_pkg for the result type.
module dlr_checker
  import dlr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input result_t     result_o
);

  // an empty frame is one closing result with zero length
  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.byte_valid) |->
      (result_o.last_in_frame && result_o.frame_length == 6'd0 && !result_o.truncated))
    else $error("empty-frame result malformed");

  // bytes of one frame share length and truncation flag
  a_frame_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !result_o.last_in_frame) |=>
      (empty || (result_o.frame_length == $past(result_o.frame_length) &&
                 result_o.truncated == $past(result_o.truncated) &&
                 result_o.byte_valid)))
    else $error("frame fields changed inside a frame");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result dropped or changed");

endmodule

bind delimited_line_receiver_unit dlr_checker u_dlr_checker (.*);

FILE: bench/tb_delimited_line_receiver_unit.sv
`timescale 1ns / 1ps
// Testbench of delimited_line_receiver_unit: directed and random UART byte streams in all
// receive modes, each result checked against a line framer model kept in this file.
// Depends on dlr_pkg and the RTL of the block.
module tb_delimited_line_receiver_unit;
  import dlr_pkg::*;

  localparam int unsigned DEPTH         = BUFFER_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam logic [1:0]  MODE_RESERVED = 2'd3;
  localparam logic [7:0]  CR            = 8'h0D;
  localparam logic [7:0]  LF            = 8'h0A;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  in_item_t    in_item_i   = '0;
  logic        empty;
  logic        pop         = 1'b0;
  result_t     result_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = '0;
  logic [63:0] cfg_wdata_i = '0;

  // Framer model: configuration copy and line state
  logic [1:0]  rx_mode;
  logic [3:0]  term_len_reg;
  logic [63:0] term_lo_reg;
  logic [55:0] term_hi_reg;
  logic [7:0]  line_buf [DEPTH];
  int unsigned line_fill;
  int unsigned line_total;
  int unsigned term_pos;
  result_t     pending_frame_bytes[$];

  int unsigned mismatches     = 0;
  int unsigned accepted_bytes = 0;
  int unsigned cycle_count    = 0;
  int unsigned pop_hold       = 0;
  int unsigned push_gap_pct   = 0;
  int unsigned pop_stall_pct  = 0;
  bit          quiet          = 1'b0;
  result_t     want;

  delimited_line_receiver_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic result_t make_result(input logic [7:0] data, input logic valid,
                                          input logic last, input int unsigned len,
                                          input logic trunc);
    result_t r;
    r.data_byte     = data;
    r.byte_valid    = valid;
    r.last_in_frame = last;
    r.frame_length  = 6'(len);
    r.truncated     = trunc;
    return r;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("data %02h valid %0b last %0b length %0d truncated %0b",
                     r.data_byte, r.byte_valid, r.last_in_frame, r.frame_length, r.truncated);
  endfunction

  function automatic logic [7:0] term_byte_at(input int unsigned pos);
    if (pos < 8) return term_lo_reg[8*pos +: 8];
    return term_hi_reg[8*(pos-8) +: 8];
  endfunction

  function automatic int unsigned eff_term_len();
    return (term_len_reg == 4'd0) ? 1 : int'(term_len_reg);
  endfunction

  task automatic reset_line_model();
    rx_mode      = MODE_TERM;
    term_len_reg = TERM_LEN_RST;
    term_lo_reg  = TERM_LOW_RST;
    term_hi_reg  = '0;
    line_fill    = 0;
    line_total   = 0;
    term_pos     = 0;
  endtask

  // Append the results one accepted byte causes.
  task automatic predict_line(input in_item_t item);
    int unsigned len;
    int unsigned payload;
    int unsigned n;
    logic        trunc;
    if (!item.rx_complete) return;
    if (rx_mode == MODE_CHAR) begin
      pending_frame_bytes.push_back(make_result(item.rx_byte, 1'b1, 1'b1, 1, 1'b0));
      return;
    end
    if (rx_mode != MODE_TERM) return;
    len = eff_term_len();
    if (line_fill < DEPTH) begin
      line_buf[line_fill] = item.rx_byte;
      line_fill++;
    end
    if (line_total < 255) line_total++;
    if (term_pos >= len) term_pos = 0;
    // a mismatch restarts at position 0 without a second compare
    if (item.rx_byte != term_byte_at(term_pos)) begin
      term_pos = 0;
      return;
    end
    term_pos++;
    if (term_pos < len) return;
    payload = (line_total >= len) ? line_total - len : 0;
    trunc   = (payload > DEPTH);
    n       = trunc ? DEPTH : payload;
    if (n > line_fill) n = line_fill;
    line_fill  = 0;
    line_total = 0;
    term_pos   = 0;
    if (n == 0) begin
      pending_frame_bytes.push_back(make_result(8'h00, 1'b0, 1'b1, 0, trunc));
      return;
    end
    for (int unsigned i = 0; i < n; i++)
      pending_frame_bytes.push_back(make_result(line_buf[i], 1'b1, (i + 1 == n), n, trunc));
  endtask

  // Leave push high on return so back-to-back requests need no second assignment.
  task automatic send_rx(input logic [7:0] b, input logic done);
    in_item_t item;
    item.rx_byte     = b;
    item.rx_complete = done;
    if (!quiet && $urandom_range(0, 99) < push_gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= item;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    accepted_bytes++;
    predict_line(item);
  endtask

  // Drop push, drain every expected result, then let the block settle.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_frame_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_RECEIVE_MODE: rx_mode      = value[1:0];
      REG_TERM_LENGTH:  term_len_reg = value[3:0];
      REG_TERM_LOW:     term_lo_reg  = value;
      REG_TERM_HIGH:    term_hi_reg  = value[55:0];
      default: ;
    endcase
  endtask

  // Unused upper write data bits carry noise; the registers must ignore them.
  task automatic set_line_config(input logic [1:0] mode, input logic [3:0] len,
                                 input logic [63:0] lo, input logic [55:0] hi);
    write_reg(REG_RECEIVE_MODE, {62'($urandom), mode});
    write_reg(REG_TERM_LENGTH, {60'($urandom), len});
    write_reg(REG_TERM_LOW, lo);
    write_reg(REG_TERM_HIGH, {8'($urandom), hi});
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_frame_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: %s", fmt_result(result_o));
        end else begin
          want = pending_frame_bytes.pop_front();
          if (result_o.data_byte !== want.data_byte || result_o.byte_valid !== want.byte_valid ||
              result_o.last_in_frame !== want.last_in_frame ||
              result_o.frame_length !== want.frame_length ||
              result_o.truncated !== want.truncated) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result mismatch: expected %s, got %s", fmt_result(want),
                       fmt_result(result_o));
          end
        end
      end
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else if (!quiet && $urandom_range(0, 99) < pop_stall_pct) begin
        pop      <= 1'b0;
        pop_hold = $urandom_range(0, 12);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic test_reset_defaults();
    send_rx(8'h41, 1'b1);
    send_rx(8'hFF, 1'b0);
    send_rx(8'h00, 1'b1);
    send_rx(CR, 1'b1);
    send_rx(LF, 1'b1);
    // empty line
    send_rx(CR, 1'b1);
    send_rx(LF, 1'b1);
    // second CR breaks the match; the line ends at the next CR LF
    send_rx(CR, 1'b1);
    send_rx(CR, 1'b1);
    send_rx(LF, 1'b1);
    send_rx(CR, 1'b1);
    send_rx(LF, 1'b1);
    wait_idle();
  endtask

  task automatic test_char_mode();
    write_reg(REG_RECEIVE_MODE, 64'(MODE_CHAR));
    send_rx(8'h00, 1'b1);
    send_rx(8'hFF, 1'b1);
    send_rx(8'h55, 1'b0);
    wait_idle();
  endtask

  task automatic test_dropped_modes();
    write_reg(REG_RECEIVE_MODE, 64'(MODE_TERM));
    send_rx(8'h58, 1'b1);
    wait_idle();
    write_reg(REG_RECEIVE_MODE, 64'(MODE_NONE));
    send_rx(8'h59, 1'b1);
    wait_idle();
    write_reg(REG_RECEIVE_MODE, 64'(MODE_RESERVED));
    send_rx(8'h5A, 1'b1);
    wait_idle();
    // line state kept across the drop modes
    write_reg(REG_RECEIVE_MODE, 64'(MODE_TERM));
    send_rx(CR, 1'b1);
    send_rx(LF, 1'b1);
    wait_idle();
  endtask

  task automatic test_stale_match_position();
    send_rx(CR, 1'b1);
    wait_idle();
    // position 1 is now past the shorter terminator
    write_reg(REG_TERM_LENGTH, 64'd1);
    send_rx(CR, 1'b1);
    wait_idle();
  endtask

  task automatic test_zero_length();
    write_reg(REG_TERM_LOW, 64'(LF));
    write_reg(REG_TERM_LENGTH, 64'd0);
    send_rx(8'h61, 1'b1);
    send_rx(LF, 1'b1);
    wait_idle();
  endtask

  function automatic logic [7:0] pick_byte(input bit narrow);
    if (narrow) return $urandom_range(0, 1) ? CR : LF;
    return 8'($urandom);
  endfunction

  task automatic send_random_line(input bit narrow);
    int unsigned plen;
    int unsigned cut;
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
    for (int unsigned k = 0; k < plen; k++) begin
      if ($urandom_range(0, 9) == 0) send_rx(8'($urandom), 1'b0);
      send_rx(pick_byte(narrow), 1'b1);
    end
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(0, eff_term_len() - 1);
      for (int unsigned k = 0; k < cut; k++) send_rx(term_byte_at(k), 1'b1);
      send_rx(~term_byte_at(cut), 1'b1);
    end
    for (int unsigned k = 0; k < eff_term_len(); k++) send_rx(term_byte_at(k), 1'b1);
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned pick;
    logic [1:0]  mode;
    logic [3:0]  len;
    logic [63:0] lo;
    logic [55:0] hi;
    bit          narrow;
    phase = 0;
    while (accepted_bytes < 100) begin
      if (accepted_bytes >= 80) begin
        quiet = 1'b1;
      end else begin
        pick          = $urandom_range(0, 2);
        push_gap_pct  = (pick == 0) ? 0 : (pick == 1) ? 20 : 50;
        pick          = $urandom_range(0, 2);
        pop_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 20 : 50;
      end
      mode   = MODE_TERM;
      narrow = ($urandom_range(0, 9) < 4);
      lo     = {$urandom, $urandom};
      hi     = 56'({$urandom, $urandom});
      pick   = $urandom_range(0, 9);
      len    = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd1 : (pick < 4) ? 4'd15 :
               (pick < 6) ? 4'd2 : 4'($urandom_range(1, 15));
      case (phase)
        0: begin
          len = 4'd15;
          lo  = '1;
          hi  = '1;
          narrow = 1'b0;
        end
        1: begin
          len = 4'd1;
          lo  = '0;
          hi  = '0;
          narrow = 1'b0;
        end
        2: begin
          len = 4'd15;
          narrow = 1'b1;
        end
        default: begin
          pick = $urandom_range(0, 9);
          mode = (pick < 6) ? MODE_TERM : (pick < 8) ? MODE_CHAR :
                 (pick == 8) ? MODE_NONE : MODE_RESERVED;
        end
      endcase
      if (narrow) begin
        for (int unsigned k = 0; k < 15; k++) begin
          if (k < 8) lo[8*k +: 8] = pick_byte(1'b1);
          else hi[8*(k-8) +: 8] = pick_byte(1'b1);
        end
      end
      set_line_config(mode, len, lo, hi);
      if (mode == MODE_TERM) begin
        repeat ($urandom_range(1, 4)) send_random_line(narrow);
      end else begin
        repeat ($urandom_range(5, 15))
          send_rx(8'($urandom), ($urandom_range(0, 99) >= 15));
      end
      wait_idle();
      phase++;
    end
  endtask

  initial begin
    reset_line_model();
    push_gap_pct  = 30;
    pop_stall_pct = 30;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_char_mode();
    test_dropped_modes();
    test_stale_match_position();
    test_zero_length();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dlr_pkg.sv
hw/rtl/dlr_cmd_fifo.sv
hw/rtl/dlr_front.sv
hw/rtl/dlr_back.sv
hw/rtl/delimited_line_receiver_unit.sv
hw/rtl/dlr_checker.sv
bench/tb_delimited_line_receiver_unit.sv
